// ----- rtl/ulps_pkg.sv -----
// shared types and constants for the up/down pulse level stepper
// no dependencies; used by the channel interfaces, the step logic and the top level
package ulps_pkg;

   localparam int LEVEL_W = 5;
   localparam int REQ_W   = 8;
   localparam int TICK_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(31);

   localparam logic [TICK_W-1:0] PULSE_TICKS_RESET = TICK_W'(100);
   localparam logic [TICK_W-1:0] GAP_TICKS_RESET   = TICK_W'(100);
   localparam logic [TICK_W-1:0] HOLD_TICKS_RESET  = TICK_W'(5000);
   localparam logic [TICK_W-1:0] POLL_TICKS_RESET  = TICK_W'(50);

   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TICKS   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_POLL_TICKS  = 2'd3;

   localparam logic OPC_TICK    = 1'b0;
   localparam logic OPC_REQUEST = 1'b1;

   typedef enum logic [2:0] {
      PH_STARTUP    = 3'd0,
      PH_HOLD_UP    = 3'd1,
      PH_HOLD_DOWN  = 3'd2,
      PH_PULSE_UP   = 3'd3,
      PH_PULSE_DOWN = 3'd4,
      PH_GAP        = 3'd5,
      PH_POLL       = 3'd6
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] pulse_ticks;
      logic [TICK_W-1:0] gap_ticks;
      logic [TICK_W-1:0] reset_hold_ticks;
      logic [TICK_W-1:0] poll_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type                phase;
      logic signed [REQ_W-1:0]  requested_level;
      logic [LEVEL_W-1:0]       present_level;
      logic [TICK_W-1:0]        wait_count;
   } state_type;

   typedef struct packed {
      logic               raise_pin;
      logic               lower_pin;
      logic [LEVEL_W-1:0] current_level;
      logic               level_changed;
      logic               busy_res;
   } result_type;

endpackage

// ----- rtl/ulps_req_if.sv -----
// request channel: tick or new requested level
// depends on ulps_pkg for field widths
interface ulps_req_if;
   import ulps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    opcode;
   logic signed [REQ_W-1:0] request_level;

   modport source (output valid, output opcode, output request_level, input ready);
   modport sink   (input valid, input opcode, input request_level, output ready);
endinterface

// ----- rtl/ulps_rsp_if.sv -----
// result channel: pin levels, tracked level and status
// depends on ulps_pkg for field widths
interface ulps_rsp_if;
   import ulps_pkg::*;

   logic               valid;
   logic               ready;
   logic               raise_pin;
   logic               lower_pin;
   logic [LEVEL_W-1:0] current_level;
   logic               level_changed;
   logic               busy_res;

   modport source (output valid, output raise_pin, output lower_pin, output current_level,
                   output level_changed, output busy_res, input ready);
   modport sink   (input valid, input raise_pin, input lower_pin, input current_level,
                   input level_changed, input busy_res, output ready);
endinterface

// ----- rtl/ulps_step.sv -----
// next-state and result logic for one tick or request transfer
// depends on ulps_pkg for the phase enum and the state, config and result structs
module ulps_step (
   input  ulps_pkg::state_type            cur,
   input  ulps_pkg::cfg_type              cfg,
   input  logic                           opcode,
   input  logic signed [ulps_pkg::REQ_W-1:0] request_level,
   output ulps_pkg::state_type            nxt,
   output ulps_pkg::result_type           res
);
   import ulps_pkg::*;

   logic [TICK_W-1:0]  dur_raw;
   logic [TICK_W-1:0]  dur;
   logic [TICK_W-1:0]  count_inc;
   logic               phase_done;
   logic [LEVEL_W-1:0] lvl_upd;
   logic signed [REQ_W-1:0] lvl_ext;
   logic               lvl_changed;

   // duration of the running phase, zero acts as one
   always_comb begin
      case (cur.phase)
         PH_STARTUP, PH_HOLD_UP, PH_HOLD_DOWN: dur_raw = cfg.reset_hold_ticks;
         PH_PULSE_UP, PH_PULSE_DOWN:           dur_raw = cfg.pulse_ticks;
         PH_GAP:                               dur_raw = cfg.gap_ticks;
         default:                              dur_raw = cfg.poll_ticks;
      endcase
      dur = (dur_raw == '0) ? TICK_W'(1) : dur_raw;
   end

   assign count_inc  = cur.wait_count + TICK_W'(1);
   assign phase_done = (count_inc >= dur);

   always_comb begin
      case (cur.phase)
         PH_STARTUP, PH_HOLD_UP: lvl_upd = MAX_LEVEL;
         PH_HOLD_DOWN:           lvl_upd = '0;
         PH_PULSE_UP:            lvl_upd = cur.present_level + LEVEL_W'(1);
         PH_PULSE_DOWN:          lvl_upd = cur.present_level - LEVEL_W'(1);
         default:                lvl_upd = cur.present_level;
      endcase
   end

   assign lvl_ext = REQ_W'({1'b0, lvl_upd});

   // next state
   always_comb begin
      nxt = cur;
      lvl_changed = 1'b0;
      if (opcode == OPC_REQUEST) begin
         nxt.requested_level = request_level;
      end else begin
         nxt.wait_count = count_inc;
         if (phase_done) begin
            nxt.present_level = lvl_upd;
            lvl_changed = (cur.phase != PH_GAP) && (cur.phase != PH_POLL);
            if ((cur.phase == PH_PULSE_UP || cur.phase == PH_PULSE_DOWN) &&
                (cfg.gap_ticks != '0)) begin
               nxt.phase      = PH_GAP;
               nxt.wait_count = '0;
            end else begin
               nxt.wait_count = '0;
               // decision on the stored request against the updated level
               if (cur.requested_level > REQ_W'($signed({1'b0, MAX_LEVEL}))) begin
                  nxt.requested_level = REQ_W'($signed({1'b0, MAX_LEVEL}));
                  nxt.phase = PH_HOLD_UP;
               end else if (cur.requested_level < 0) begin
                  nxt.requested_level = '0;
                  nxt.phase = PH_HOLD_DOWN;
               end else if (cur.requested_level > lvl_ext) begin
                  nxt.phase = PH_PULSE_UP;
               end else if (cur.requested_level < lvl_ext) begin
                  nxt.phase = PH_PULSE_DOWN;
               end else begin
                  nxt.phase = PH_POLL;
               end
            end
         end
      end
   end

   // pin outputs follow the phase after this transfer
   always_comb begin
      res.raise_pin     = !(nxt.phase == PH_STARTUP || nxt.phase == PH_HOLD_UP ||
                            nxt.phase == PH_PULSE_UP);
      res.lower_pin     = !(nxt.phase == PH_HOLD_DOWN || nxt.phase == PH_PULSE_DOWN);
      res.current_level = nxt.present_level;
      res.level_changed = lvl_changed;
      res.busy_res      = 1'b1;
   end

endmodule

// ----- rtl/updown_pulse_level_stepper_core.sv -----
// top level of the up/down pulse level stepper: state, timing registers, result register
// depends on ulps_pkg, ulps_req_if, ulps_rsp_if and ulps_step

// Steps a power level toward the requested level by driving active-low raise and lower
// pins. Each request transfer is a one millisecond tick (opcode 0) or a new requested level
// (opcode 1); every transfer yields exactly one result with the pin levels after it, the
// tracked level and whether the level changed. After reset the raise pin is held for
// reset_hold_ticks ticks before the level is taken as 31. One transfer is taken every
// clock cycle: the whole update is a single combinational pass from the state registers
// into the result register, so a result is valid the cycle after its transfer, and a
// transfer is taken whenever that register is empty or being read. Not enforced here, so
// the user must write timing registers via the csr port while no transfer is in flight.
module updown_pulse_level_stepper_core (
   input  logic                              clock,
   input  logic                              reset,
   ulps_req_if.sink                          req_chan,
   ulps_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [ulps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ulps_pkg::TICK_W-1:0]       csr_wdata
);
   import ulps_pkg::*;

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       req_xfer;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   ulps_step u_step (
      .cur           (state_ff),
      .cfg           (cfg_ff),
      .opcode        (req_chan.opcode),
      .request_level (req_chan.request_level),
      .nxt           (state_in),
      .res           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_ticks      <= PULSE_TICKS_RESET;
         cfg_ff.gap_ticks        <= GAP_TICKS_RESET;
         cfg_ff.reset_hold_ticks <= HOLD_TICKS_RESET;
         cfg_ff.poll_ticks       <= POLL_TICKS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PULSE_TICKS: cfg_ff.pulse_ticks      <= csr_wdata;
            CSR_GAP_TICKS:   cfg_ff.gap_ticks        <= csr_wdata;
            CSR_HOLD_TICKS:  cfg_ff.reset_hold_ticks <= csr_wdata;
            CSR_POLL_TICKS:  cfg_ff.poll_ticks       <= csr_wdata;
            default:         cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= PH_STARTUP;
         state_ff.requested_level <= REQ_W'($signed({1'b0, MAX_LEVEL}));
         state_ff.present_level   <= MAX_LEVEL;
         state_ff.wait_count      <= '0;
      end else if (req_xfer) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.raise_pin     = rsp_ff.raise_pin;
   assign rsp_chan.lower_pin     = rsp_ff.lower_pin;
   assign rsp_chan.current_level = rsp_ff.current_level;
   assign rsp_chan.level_changed = rsp_ff.level_changed;
   assign rsp_chan.busy_res      = rsp_ff.busy_res;

endmodule
